// ===== rtl/lfwc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfwc_pkg
// Shared sizes, opcodes and status codes of the looping frame window cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lfwc_pkg;

  localparam int CACHE_DEPTH = 512;
  localparam int ADDR_W      = $clog2(CACHE_DEPTH);
  localparam int FILL_W      = ADDR_W + 1;
  localparam int FRAME_BITS  = 16;
  localparam int TAG_W       = FRAME_BITS + 1;   // valid bit on top of the tag

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_COUNT  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_HELD = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic REG_LOOP_FRAMES = 1'b0;
  localparam logic REG_CACHE_LIMIT = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/lfwc_ram.sv =====
// ----------------------------------------------------------------------------
// lfwc_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lfwc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/looping_frame_window_cache.sv =====
// ----------------------------------------------------------------------------
// looping_frame_window_cache
// Tag store and age queue for a looping frame buffer: insert, lookup, count.
// ----------------------------------------------------------------------------
// One word at a time: start is taken while busy is low, the result shows on
// out_* for one cycle with out_valid and cannot be held off. Every search is
// a walk over the tag RAM, one slot a cycle, ending early on a hit. Lookup
// takes one walk. Insert takes one walk, then an ageing pass that reads,
// checks and keeps or drops each queued entry, then one limit eviction per
// entry over the limit. Count first reduces the position modulo the loop
// length, then takes one walk per frame counted plus one for the missing
// frame that ends the run, at most max_check walks. Opcode 3 answers
// straight from idle. After reset a clearing pass over all CACHE_DEPTH slots
// runs with busy high.
`default_nettype none

module looping_frame_window_cache (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_position,
  input  wire logic [15:0] in_frame_number,
  input  wire logic [9:0]  in_max_check,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [15:0]      out_found_frame,
  output logic [9:0]       out_buffered_count,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = lfwc_pkg::ADDR_W;
  localparam int FW = lfwc_pkg::FILL_W;
  localparam int TB = lfwc_pkg::FRAME_BITS;
  localparam int TW = lfwc_pkg::TAG_W;
  localparam logic [FW-1:0] DEPTH_F = FW'(lfwc_pkg::CACHE_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(lfwc_pkg::CACHE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_SCAN, S_DISP, S_INS_NEW, S_INS_POP, S_INS_FULL,
    S_CMP_RQ, S_CMP_RT, S_CMP_CHK, S_LIM_RQ, S_LIM_W
  } state_t;

  state_t            state_r;
  lfwc_pkg::opcode_t op_r;
  logic [TB-1:0]     pos_r, frame_r, idx_r, held_frame_r;
  logic [9:0]        maxc_r, cnt_r;
  logic              held_present_r;
  logic [15:0]       loop_r;
  logic [9:0]        limit_r;
  logic [AW-1:0]     head_r, clr_addr_r, slot_r;
  logic [FW-1:0]     fill_r, i_r, kept_r;
  logic [AW-1:0]     scan_addr_r, pend_addr_r, free_slot_r;
  logic              pend_r, hit_a_r, hit_b_r, free_found_r;
  logic [TB-1:0]     rem_r;
  logic [3:0]        dbit_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [15:0]       out_found_r;
  logic [9:0]        out_count_r;

  // RAM ports
  logic          tag_we, q_we;
  logic [AW-1:0] tag_wa, tag_ra, q_wa, q_ra;
  logic [TW-1:0] tag_wd, tag_rd;
  logic [AW-1:0] q_wd, q_rd;

  lfwc_ram #(.WIDTH(TW), .DEPTH(lfwc_pkg::CACHE_DEPTH)) u_tag (
    .clk(clk), .wr_en(tag_we), .wr_addr(tag_wa), .wr_data(tag_wd),
    .rd_addr(tag_ra), .rd_data(tag_rd)
  );

  lfwc_ram #(.WIDTH(AW), .DEPTH(lfwc_pkg::CACHE_DEPTH)) u_queue (
    .clk(clk), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
    .rd_addr(q_ra), .rd_data(q_rd)
  );

  // search keys and matches on the word coming out of the tag RAM
  logic [TB-1:0] key_a;
  logic          match_a, match_b;
  always_comb begin
    unique case (op_r)
      lfwc_pkg::OP_INSERT: key_a = frame_r;
      lfwc_pkg::OP_LOOKUP: key_a = pos_r;
      default:             key_a = idx_r;
    endcase
  end
  assign match_a = pend_r && tag_rd[TW-1] && (tag_rd[TB-1:0] == key_a);
  assign match_b = pend_r && tag_rd[TW-1] && (tag_rd[TB-1:0] == held_frame_r);

  // wrapped distance of the tag under check to the position
  logic signed [17:0] dist_raw, half_s, len_s, dist_w;
  logic               behind;
  always_comb begin
    len_s    = $signed({2'b00, loop_r});
    half_s   = $signed({3'b000, loop_r[15:1]});
    dist_raw = $signed({2'b00, tag_rd[TB-1:0]}) - $signed({2'b00, pos_r});
    if (dist_raw < -half_s) begin
      dist_w = dist_raw + len_s;
    end else if (dist_raw > half_s) begin
      dist_w = dist_raw - len_s;
    end else begin
      dist_w = dist_raw;
    end
    behind = dist_w[17];
  end

  logic [9:0]    limit_eff;
  logic [16:0]   div_sh;
  logic [TB-1:0] idx_next;
  logic [9:0]    cnt_inc;
  logic [AW-1:0] head_i, head_kept, head_fill;
  assign limit_eff = (limit_r > 10'(lfwc_pkg::CACHE_DEPTH)) ?
                     10'(lfwc_pkg::CACHE_DEPTH) : limit_r;
  assign div_sh    = {rem_r, pos_r[dbit_r]};
  assign idx_next  = (loop_r == 16'd0) ? '0 :
                     (({1'b0, idx_r} + 17'd1) == {1'b0, loop_r}) ? '0 : idx_r + 1'b1;
  assign cnt_inc   = cnt_r + 10'd1;
  assign head_i    = head_r + i_r[AW-1:0];
  assign head_kept = head_r + kept_r[AW-1:0];
  assign head_fill = head_r + fill_r[AW-1:0];

  always_comb begin
    tag_we = 1'b0;
    tag_wa = slot_r;
    tag_wd = '0;
    tag_ra = scan_addr_r;
    q_we   = 1'b0;
    q_wa   = head_kept;
    q_wd   = slot_r;
    q_ra   = head_r;
    unique case (state_r)
      S_CLEAR: begin
        tag_we = 1'b1;
        tag_wa = clr_addr_r;
      end
      S_INS_NEW: begin
        tag_we = 1'b1;
        tag_wa = free_slot_r;
        tag_wd = {1'b1, frame_r};
        q_we   = 1'b1;
        q_wa   = head_fill;
        q_wd   = free_slot_r;
      end
      S_INS_FULL: begin
        tag_we = 1'b1;
        tag_wa = q_rd;
        tag_wd = {1'b1, frame_r};
      end
      S_CMP_RQ: q_ra = head_i;
      S_CMP_RT: tag_ra = q_rd;
      S_CMP_CHK: begin
        tag_we = behind;
        q_we   = !behind;
      end
      S_LIM_W: begin
        tag_we = 1'b1;
        tag_wa = q_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    out_valid_r <= 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        lfwc_pkg::REG_LOOP_FRAMES: loop_r  <= cfg_data;
        lfwc_pkg::REG_CACHE_LIMIT: limit_r <= cfg_data[9:0];
      endcase
    end
    unique case (state_r)
      S_CLEAR: begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_A) begin
          state_r <= S_IDLE;
        end
      end
      S_IDLE: begin
        scan_addr_r  <= '0;
        pend_r       <= 1'b0;
        hit_a_r      <= 1'b0;
        hit_b_r      <= 1'b0;
        free_found_r <= 1'b0;
        if (start) begin
          op_r    <= lfwc_pkg::opcode_t'(in_opcode);
          pos_r   <= in_position;
          frame_r <= in_frame_number;
          maxc_r  <= in_max_check;
          cnt_r   <= '0;
          idx_r   <= '0;
          rem_r   <= '0;
          dbit_r  <= 4'(TB - 1);
          unique case (lfwc_pkg::opcode_t'(in_opcode))
            lfwc_pkg::OP_INSERT, lfwc_pkg::OP_LOOKUP: state_r <= S_SCAN;
            lfwc_pkg::OP_COUNT: begin
              if (in_max_check == 10'd0) begin
                out_valid_r  <= 1'b1;
                out_status_r <= lfwc_pkg::ST_DONE;
                out_found_r  <= '0;
                out_count_r  <= '0;
              end else if (loop_r == 16'd0) begin
                state_r <= S_SCAN;
              end else begin
                state_r <= S_DIV;
              end
            end
            default: begin
              out_valid_r  <= 1'b1;
              out_status_r <= lfwc_pkg::ST_DONE;
              out_found_r  <= '0;
              out_count_r  <= '0;
            end
          endcase
        end
      end
      S_DIV: begin
        // restoring reduction of the start position modulo the loop length
        if (div_sh >= {1'b0, loop_r}) begin
          rem_r <= TB'(div_sh - {1'b0, loop_r});
        end else begin
          rem_r <= TB'(div_sh);
        end
        dbit_r <= dbit_r - 1'b1;
        if (dbit_r == 4'd0) begin
          idx_r   <= (div_sh >= {1'b0, loop_r}) ?
                     TB'(div_sh - {1'b0, loop_r}) : TB'(div_sh);
          state_r <= S_SCAN;
        end
      end
      S_SCAN: begin
        scan_addr_r <= scan_addr_r + 1'b1;
        pend_addr_r <= scan_addr_r;
        pend_r      <= 1'b1;
        if (match_a) hit_a_r <= 1'b1;
        if (match_b) hit_b_r <= 1'b1;
        if (pend_r && !tag_rd[TW-1] && !free_found_r) begin
          free_found_r <= 1'b1;
          free_slot_r  <= pend_addr_r;
        end
        if (match_a || (pend_r && pend_addr_r == LAST_A)) begin
          state_r <= S_DISP;
        end
      end
      S_DISP: begin
        scan_addr_r  <= '0;
        pend_r       <= 1'b0;
        hit_a_r      <= 1'b0;
        hit_b_r      <= 1'b0;
        free_found_r <= 1'b0;
        i_r          <= '0;
        kept_r       <= '0;
        unique case (op_r)
          lfwc_pkg::OP_INSERT: begin
            if (hit_a_r) begin
              state_r <= S_CMP_RQ;
            end else if (fill_r == DEPTH_F) begin
              state_r <= S_INS_POP;
            end else begin
              state_r <= S_INS_NEW;
            end
          end
          lfwc_pkg::OP_LOOKUP: begin
            out_valid_r <= 1'b1;
            out_count_r <= '0;
            state_r     <= S_IDLE;
            if (hit_a_r) begin
              held_frame_r   <= pos_r;
              held_present_r <= 1'b1;
              out_status_r   <= lfwc_pkg::ST_HIT;
              out_found_r    <= pos_r;
            end else if (held_present_r && hit_b_r) begin
              out_status_r <= lfwc_pkg::ST_HELD;
              out_found_r  <= held_frame_r;
            end else begin
              out_status_r <= lfwc_pkg::ST_MISS;
              out_found_r  <= '0;
            end
          end
          default: begin
            if (hit_a_r && cnt_inc != maxc_r) begin
              cnt_r   <= cnt_inc;
              idx_r   <= idx_next;
              state_r <= S_SCAN;
            end else begin
              out_valid_r  <= 1'b1;
              out_status_r <= lfwc_pkg::ST_DONE;
              out_found_r  <= '0;
              out_count_r  <= hit_a_r ? cnt_inc : cnt_r;
              state_r      <= S_IDLE;
            end
          end
        endcase
      end
      S_INS_NEW: begin
        fill_r  <= fill_r + 1'b1;
        state_r <= S_CMP_RQ;
      end
      S_INS_POP: state_r <= S_INS_FULL;
      S_INS_FULL: begin
        // full store: the oldest slot takes the new frame, queue word unchanged
        head_r  <= head_r + 1'b1;
        state_r <= S_CMP_RQ;
      end
      S_CMP_RQ: begin
        if (i_r == fill_r) begin
          fill_r  <= kept_r;
          state_r <= S_LIM_RQ;
        end else begin
          state_r <= S_CMP_RT;
        end
      end
      S_CMP_RT: begin
        slot_r  <= q_rd;
        state_r <= S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (!behind) kept_r <= kept_r + 1'b1;
        i_r     <= i_r + 1'b1;
        state_r <= S_CMP_RQ;
      end
      S_LIM_RQ: begin
        if (fill_r > FW'(limit_eff)) begin
          state_r <= S_LIM_W;
        end else begin
          out_valid_r  <= 1'b1;
          out_status_r <= lfwc_pkg::ST_DONE;
          out_found_r  <= '0;
          out_count_r  <= '0;
          state_r      <= S_IDLE;
        end
      end
      S_LIM_W: begin
        head_r  <= head_r + 1'b1;
        fill_r  <= fill_r - 1'b1;
        state_r <= S_LIM_RQ;
      end
      default: state_r <= S_IDLE;
    endcase
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_addr_r     <= '0;
      head_r         <= '0;
      fill_r         <= '0;
      held_frame_r   <= '0;
      held_present_r <= 1'b0;
      loop_r         <= 16'd1;
      limit_r        <= 10'd300;
      out_valid_r    <= 1'b0;
      pend_r         <= 1'b0;
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_frame    = out_found_r;
  assign out_buffered_count = out_count_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_F) else $error("fill beyond depth");
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> busy) else $error("not busy after reset");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid) else $error("word dropped");
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && state_r == S_IDLE && $past(state_r) == S_LIM_RQ |->
    fill_r <= FW'(limit_eff)) else $error("limit not met");
`endif

endmodule

`default_nettype wire
